>>> rtl/sitld_pkg.sv
`timescale 1ns / 1ps

package sitld_pkg;

  localparam int NUM_W      = 28;
  localparam int MAG_W      = 27;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_DECODE_MODE  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_DIGITS = 4'd1;

  localparam logic [7:0] BLANK_CODE = 8'h0F;
  localparam logic [7:0] MINUS_CODE = 8'h0A;
  localparam logic [7:0] CLEAR_CODE = 8'h00;
  localparam logic [7:0] DIGIT_BASE = 8'h30;

  localparam logic [3:0] CLEAR_DIGITS_RST = 4'd8;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SAT    = 6'b000010,
    ST_CONV   = 6'b000100,
    ST_LEN    = 6'b001000,
    ST_CLEAR  = 6'b010000,
    ST_DIGITS = 6'b100000
  } state_t;

  function automatic longint pow10(input int n);
    longint p;
    p = 1;
    for (int i = 0; i < n; i++) begin
      p = p * 10;
    end
    return p;
  endfunction

endpackage

>>> rtl/signed_int_to_led_digit_writes.sv
`timescale 1ns / 1ps

// an accepted input beat passes through ST_SAT, ST_CONV and ST_LEN before the
// first write beat; numbers are taken one at a time, paced by the binary to bcd
// 27-step bit-serial shift and one write beat per cycle while out_ready is high
// a new number is taken while the final write beat still waits at the output
// rst_n is synchronous, active low: control idles, decode_mode 0, clear_digits 8

module signed_int_to_led_digit_writes #(
  parameter int DIGIT_COUNT = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [sitld_pkg::NUM_W-1:0] in_number_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [3:0]                        out_reg_address,
  output logic [7:0]                        out_reg_data,
  output logic                              out_last_write,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sitld_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sitld_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import sitld_pkg::*;

  localparam int BCD_W = 4 * DIGIT_COUNT;
  localparam logic signed [NUM_W-1:0] SAT_HI = NUM_W'(pow10(DIGIT_COUNT) - 1);
  localparam logic signed [NUM_W-1:0] SAT_LO = NUM_W'(1 - pow10(DIGIT_COUNT - 1));
  localparam logic [3:0] DC4 = 4'(DIGIT_COUNT);
  localparam logic [4:0] LAST_STEP = 5'(MAG_W - 1);

  state_t                   state_r, state_nxt;
  logic signed [NUM_W-1:0]  num_r, num_nxt;
  logic                     neg_r, neg_nxt;
  logic [MAG_W-1:0]         mag_r, mag_nxt;
  logic [BCD_W-1:0]         bcd_r, bcd_nxt;
  logic [4:0]               cnt_r, cnt_nxt;
  logic [3:0]               blank_r, blank_nxt;
  logic [3:0]               addr_r, addr_nxt;
  logic [7:0]               decode_mode_r;
  logic [3:0]               clear_digits_r;
  logic                     out_valid_r, out_valid_nxt;
  logic [3:0]               out_addr_r, out_addr_nxt;
  logic [7:0]               out_data_r, out_data_nxt;
  logic                     out_last_r, out_last_nxt;

  logic                     emit_ok;
  logic [3:0]               top;
  logic [BCD_W-1:0]         adj;
  logic [3:0]               nd;
  logic signed [NUM_W-1:0]  sat_v;

  assign in_ready        = (state_r == ST_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_reg_address = out_addr_r;
  assign out_reg_data    = out_data_r;
  assign out_last_write  = out_last_r;

  assign emit_ok = !out_valid_r || out_ready;
  assign top     = (clear_digits_r > DC4) ? DC4 : clear_digits_r;

  always_comb begin
    for (int j = 0; j < DIGIT_COUNT; j++) begin
      adj[4*j +: 4] = (bcd_r[4*j +: 4] >= 4'd5) ? bcd_r[4*j +: 4] + 4'd3 : bcd_r[4*j +: 4];
    end
  end

  always_comb begin
    nd = 4'd1;
    for (int j = 0; j < DIGIT_COUNT; j++) begin
      if (bcd_r[4*j +: 4] != 4'd0) begin
        nd = 4'(j + 1);
      end
    end
  end

  always_comb begin
    sat_v = num_r;
    if (num_r > SAT_HI) begin
      sat_v = SAT_HI;
    end
    if (num_r < SAT_LO) begin
      sat_v = SAT_LO;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    num_nxt       = num_r;
    neg_nxt       = neg_r;
    mag_nxt       = mag_r;
    bcd_nxt       = bcd_r;
    cnt_nxt       = cnt_r;
    blank_nxt     = blank_r;
    addr_nxt      = addr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_addr_nxt  = out_addr_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          num_nxt   = in_number_value;
          state_nxt = ST_SAT;
        end
      end
      ST_SAT: begin
        neg_nxt   = sat_v[NUM_W-1];
        mag_nxt   = sat_v[NUM_W-1] ? MAG_W'(-sat_v) : MAG_W'(sat_v);
        bcd_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = ST_CONV;
      end
      ST_CONV: begin
        if (BCD_W > 1) begin
          bcd_nxt = {adj[BCD_W-2:0], mag_r[MAG_W-1]};
        end
        mag_nxt = {mag_r[MAG_W-2:0], 1'b0};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == LAST_STEP) begin
          state_nxt = ST_LEN;
        end
      end
      ST_LEN: begin
        blank_nxt = DC4 - nd - {3'b000, neg_r};
        if (decode_mode_r == 8'd0) begin
          addr_nxt  = 4'd0;
          state_nxt = ST_CLEAR;
        end else if (top == 4'd0) begin
          addr_nxt  = 4'd1;
          state_nxt = ST_DIGITS;
        end else begin
          addr_nxt  = 4'd1;
          state_nxt = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        if (emit_ok) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = addr_r;
          out_data_nxt  = (decode_mode_r == 8'd0) ? CLEAR_CODE : BLANK_CODE;
          out_last_nxt  = 1'b0;
          if (addr_r == top) begin
            addr_nxt  = 4'd1;
            state_nxt = ST_DIGITS;
          end else begin
            addr_nxt = addr_r + 4'd1;
          end
        end
      end
      ST_DIGITS: begin
        if (emit_ok) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = addr_r;
          out_last_nxt  = (addr_r == DC4);
          if (addr_r <= blank_r) begin
            out_data_nxt = BLANK_CODE;
          end else if (neg_r && addr_r == DC4) begin
            out_data_nxt = MINUS_CODE;
          end else begin
            out_data_nxt = DIGIT_BASE + {4'b0000, bcd_r[3:0]};
            bcd_nxt      = bcd_r >> 4;
          end
          addr_nxt = addr_r + 4'd1;
          if (addr_r == DC4) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      out_valid_r    <= 1'b0;
      decode_mode_r  <= 8'd0;
      clear_digits_r <= CLEAR_DIGITS_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_DECODE_MODE) begin
          decode_mode_r <= cfg_data;
        end else if (cfg_index == CFG_CLEAR_DIGITS) begin
          clear_digits_r <= cfg_data[3:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    num_r      <= num_nxt;
    neg_r      <= neg_nxt;
    mag_r      <= mag_nxt;
    bcd_r      <= bcd_nxt;
    cnt_r      <= cnt_nxt;
    blank_r    <= blank_nxt;
    addr_r     <= addr_nxt;
    out_addr_r <= out_addr_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

`ifndef SYNTHESIS
  a_last_on_top_reg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> out_addr_r == DC4)
    else $error("final write beat not on top digit register");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a number is in flight");

  a_noop_reg_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_addr_r == 4'd0 |-> out_data_r == CLEAR_CODE)
    else $error("register zero written with nonzero data");

  a_conv_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CONV |-> cnt_r <= LAST_STEP)
    else $error("bcd shift count overran");
`endif

endmodule
